// ----- src/hpe_pkg.sv -----
// shared types, constants and helpers for the hold-and-modify pixel encoder
`default_nettype none
package hpe_pkg;

  localparam int PALETTE_SIZE_DEF = 64;

  // initial search bounds, 3*E*E for HAM8 and HAM6
  localparam logic [15:0] BOUND_HAM8 = 16'd12288;
  localparam logic [15:0] BOUND_HAM6 = 16'd768;

  // control codes of a HAM byte
  localparam logic [1:0] CTRL_PALETTE = 2'd0;

  typedef struct packed {
    logic       is_write;
    logic       row_start;
    logic [5:0] blue;
    logic [5:0] red;
    logic [5:0] green;
    logic [5:0] entry;
  } item_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_SEARCH,
    S_DECIDE
  } state_t;

  // square of the absolute difference, modulo 2^16
  function automatic logic [15:0] sq8(input logic [7:0] a, input logic [7:0] b);
    logic [15:0] d;
    d = (a > b) ? {8'd0, a - b} : {8'd0, b - a};
    return d * d;
  endfunction

  // summed squared error with wraparound
  function automatic logic [15:0] err3(input logic [7:0] a0, input logic [7:0] a1,
                                       input logic [7:0] a2, input logic [7:0] b0,
                                       input logic [7:0] b1, input logic [7:0] b2);
    return 16'(sq8(a0, b0) + sq8(a1, b1) + sq8(a2, b2));
  endfunction

  // pack control and value into a HAM8 or HAM6 byte
  function automatic logic [7:0] make_byte(input logic ham8, input logic [1:0] ctrl,
                                           input logic [5:0] value);
    logic [7:0] b;
    if (ham8) begin
      b = {value, ctrl};
    end else begin
      b = {2'b00, ctrl, value[3:0]};
    end
    return b;
  endfunction

endpackage
`default_nettype wire

// ----- src/hpe_front.sv -----
// front end: classifies input beats and queues them for the back end
`default_nettype none
module hpe_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic          cmd,
  input  wire logic          row_start,
  input  wire logic [5:0]    blue_level,
  input  wire logic [5:0]    red_level,
  input  wire logic [5:0]    green_level,
  input  wire logic [5:0]    entry_number,
  output logic               q_valid,
  output hpe_pkg::item_t     q_item,
  input  wire logic          q_pop
);

  hpe_pkg::item_t slots [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  logic       push;
  hpe_pkg::item_t item_in;

  // classify the incoming beat
  always_comb begin
    item_in.is_write  = cmd;
    item_in.row_start = row_start & ~cmd;
    item_in.blue      = blue_level;
    item_in.red       = red_level;
    item_in.green     = green_level;
    item_in.entry     = entry_number;
  end

  assign in_stall = (cnt == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt != 2'd0);
  assign q_item   = slots[rp];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= item_in;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (q_pop) rp <= ~rp;
      cnt <= 2'(cnt + {1'b0, push} - {1'b0, q_pop});
    end
  end

endmodule
`default_nettype wire

// ----- src/hpe_back.sv -----
// back end: palette memory, palette search, modify decision and output register
`default_nettype none
module hpe_back #(
  parameter int PaletteSize = hpe_pkg::PALETTE_SIZE_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          ham8_mode,
  input  wire logic          q_valid,
  input  hpe_pkg::item_t     q_item,
  output logic               q_pop,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [7:0]         ham_byte
);

  localparam int AW = $clog2(PaletteSize);

  hpe_pkg::state_t state, state_next;

  logic [17:0] mem [PaletteSize];
  logic [17:0] rd_data;
  logic [AW-1:0] rd_addr;

  logic [5:0] pb, pr, pg;
  logic [7:0] held_b, held_r, held_g;
  logic [1:0] rotation;
  logic [AW-1:0] cnt;
  logic [15:0] best_err;
  logic [AW-1:0] best_idx;
  logic [17:0] best_rgb;

  logic slot_free;
  logic emit_check;
  logic emit_decide;
  logic search_last;
  logic pix_eq;
  logic [15:0] cur_err;
  logic [1:0] comp;
  logic [5:0] comp_val;
  logic [7:0] db, dr, dg, dbest;
  logic [7:0] mb, mr, mg;
  logic [15:0] mod_err;
  logic take_mod;
  logic [5:0] rot_val;

  assign slot_free = !out_valid || !out_stall;
  assign pix_eq = ({2'b00, pb} == held_b) && ({2'b00, pr} == held_r) &&
                  ({2'b00, pg} == held_g);
  assign search_last = (cnt == (ham8_mode ? AW'(PaletteSize - 1) : AW'(15)));

  // error of the entry on the read port
  assign cur_err = hpe_pkg::err3({2'b00, pb}, {2'b00, pr}, {2'b00, pg},
                                 {2'b00, rd_data[17:12]}, {2'b00, rd_data[11:6]},
                                 {2'b00, rd_data[5:0]});

  // component with the largest difference, first on ties
  always_comb begin
    db = ({2'b00, pb} > held_b) ? ({2'b00, pb} - held_b) : (held_b - {2'b00, pb});
    dr = ({2'b00, pr} > held_r) ? ({2'b00, pr} - held_r) : (held_r - {2'b00, pr});
    dg = ({2'b00, pg} > held_g) ? ({2'b00, pg} - held_g) : (held_g - {2'b00, pg});
    comp  = 2'd0;
    dbest = db;
    if (dr > dbest) begin
      comp  = 2'd1;
      dbest = dr;
    end
    if (dg > dbest) begin
      comp = 2'd2;
    end
    mb = held_b;
    mr = held_r;
    mg = held_g;
    unique case (comp)
      2'd0: begin
        mb = {2'b00, pb};
        comp_val = pb;
      end
      2'd1: begin
        mr = {2'b00, pr};
        comp_val = pr;
      end
      default: begin
        mg = {2'b00, pg};
        comp_val = pg;
      end
    endcase
    mod_err  = hpe_pkg::err3({2'b00, pb}, {2'b00, pr}, {2'b00, pg}, mb, mr, mg);
    take_mod = (best_err >= mod_err);
  end

  // component picked by the rotation on a repeated colour
  always_comb begin
    unique case (rotation)
      2'd0:    rot_val = pb;
      2'd1:    rot_val = pr;
      default: rot_val = pg;
    endcase
  end

  // next state and handshake
  always_comb begin
    state_next  = state;
    q_pop       = 1'b0;
    emit_check  = 1'b0;
    emit_decide = 1'b0;
    rd_addr     = AW'(cnt + AW'(1));
    unique case (state)
      hpe_pkg::S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (!q_item.is_write) state_next = hpe_pkg::S_CHECK;
        end
      end
      hpe_pkg::S_CHECK: begin
        rd_addr = '0;
        if (pix_eq) begin
          if (slot_free) begin
            emit_check = 1'b1;
            state_next = hpe_pkg::S_IDLE;
          end
        end else begin
          state_next = hpe_pkg::S_SEARCH;
        end
      end
      hpe_pkg::S_SEARCH: begin
        if (search_last) state_next = hpe_pkg::S_DECIDE;
      end
      hpe_pkg::S_DECIDE: begin
        if (slot_free) begin
          emit_decide = 1'b1;
          state_next  = hpe_pkg::S_IDLE;
        end
      end
      default: state_next = hpe_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hpe_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // palette memory
  always_ff @(posedge clk) begin
    if (q_pop && q_item.is_write && ({1'b0, q_item.entry} < 7'(PaletteSize))) begin
      mem[q_item.entry[AW-1:0]] <= {q_item.blue, q_item.red, q_item.green};
    end
    rd_data <= mem[rd_addr];
  end

  // pixel latch and search tracking
  always_ff @(posedge clk) begin
    if (q_pop) begin
      pb <= q_item.blue;
      pr <= q_item.red;
      pg <= q_item.green;
    end
    if (state == hpe_pkg::S_CHECK) begin
      cnt      <= '0;
      best_err <= ham8_mode ? hpe_pkg::BOUND_HAM8 : hpe_pkg::BOUND_HAM6;
      best_idx <= '0;
    end
    if (state == hpe_pkg::S_SEARCH) begin
      cnt <= AW'(cnt + AW'(1));
      if (cnt == '0) best_rgb <= rd_data;
      if (cur_err < best_err) begin
        best_err <= cur_err;
        best_idx <= cnt;
        best_rgb <= rd_data;
      end
    end
  end

  // held colour and rotation
  always_ff @(posedge clk) begin
    if (rst) begin
      held_b   <= 8'hFF;
      held_r   <= 8'hFF;
      held_g   <= 8'hFF;
      rotation <= 2'd0;
    end else begin
      if (q_pop && q_item.row_start) begin
        held_b   <= 8'hFF;
        held_r   <= 8'hFF;
        held_g   <= 8'hFF;
        rotation <= 2'd0;
      end
      if (emit_check) begin
        rotation <= (rotation == 2'd2) ? 2'd0 : 2'(rotation + 2'd1);
      end
      if (emit_decide) begin
        if (take_mod) begin
          held_b <= mb;
          held_r <= mr;
          held_g <= mg;
        end else begin
          held_b <= {2'b00, best_rgb[17:12]};
          held_r <= {2'b00, best_rgb[11:6]};
          held_g <= {2'b00, best_rgb[5:0]};
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_check || emit_decide) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_check) begin
      ham_byte <= hpe_pkg::make_byte(ham8_mode, 2'(rotation + 2'd1), rot_val);
    end else if (emit_decide) begin
      if (take_mod) begin
        ham_byte <= hpe_pkg::make_byte(ham8_mode, 2'(comp + 2'd1), comp_val);
      end else begin
        ham_byte <= hpe_pkg::make_byte(ham8_mode, hpe_pkg::CTRL_PALETTE, 6'(best_idx));
      end
    end
  end

endmodule
`default_nettype wire

// ----- src/ham_pixel_encoder_core.sv -----
// top level of the hold-and-modify pixel encoder
//
// Input channel: in_valid / in_stall carry one beat per item, either a palette
// write (cmd = 1, entry_number selects the entry) or a pixel to encode.
// Output channel: out_valid / out_stall carry one ham_byte per encoded pixel;
// palette writes give no output beat.
// cfg_we / cfg_wdata load ham8_mode (1 = HAM8, 0 = HAM6); the user must write it
// only while the block is idle, which the block itself does not enforce. Input
// beats enter a two-entry queue, so the sender is stalled only when it is full.
// A pixel equal to the held colour needs no search; any other pixel walks the
// palette memory one entry per cycle through its single read port: 16 entries
// in HAM6 and PaletteSize entries in HAM8.
// Reset clears the queue, out_valid, the held colour (255 each),
// the rotation and sets HAM8 mode; the palette keeps no reset value.
// A stalled output holds its byte; the back end waits before emitting the
// next one while the queue keeps filling until it stalls the sender.
`default_nettype none
module ham_pixel_encoder_core #(
  parameter int PaletteSize = hpe_pkg::PALETTE_SIZE_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic       cfg_wdata,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       cmd,
  input  wire logic       row_start,
  input  wire logic [5:0] blue_level,
  input  wire logic [5:0] red_level,
  input  wire logic [5:0] green_level,
  input  wire logic [5:0] entry_number,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      ham_byte
);

  logic           ham8_mode;
  logic           q_valid;
  logic           q_pop;
  hpe_pkg::item_t q_item;

  // mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      ham8_mode <= 1'b1;
    end else if (cfg_we) begin
      ham8_mode <= cfg_wdata;
    end
  end

  hpe_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .row_start    (row_start),
    .blue_level   (blue_level),
    .red_level    (red_level),
    .green_level  (green_level),
    .entry_number (entry_number),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop)
  );

  hpe_back #(
    .PaletteSize (PaletteSize)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .ham8_mode (ham8_mode),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ham_byte  (ham_byte)
  );

endmodule
`default_nettype wire
